FILE: sv/v3n_pkg.sv
`timescale 1ns / 1ps
// shared constants and register codes for the vector normalizer
package v3n_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int EPS_W       = 32;

    // register reset values
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd17;
    localparam int FALLBACK_X_RESET = 0;
    localparam int FALLBACK_Y_RESET = 0;
    localparam int FALLBACK_Z_RESET = 16384;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EPSILON_SQ = 2'd0,
        REG_FALLBACK_X = 2'd1,
        REG_FALLBACK_Y = 2'd2,
        REG_FALLBACK_Z = 2'd3
    } cfg_reg_t;

endpackage

FILE: sv/v3n_in_if.sv
`timescale 1ns / 1ps
// input vector channel: valid, ready and three signed components
interface v3n_in_if #(
    parameter int WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] vec_x;
    logic signed [WIDTH-1:0] vec_y;
    logic signed [WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

FILE: sv/v3n_out_if.sv
`timescale 1ns / 1ps
// result channel: valid, ready, unit vector and fallback flag
interface v3n_out_if #(
    parameter int WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] unit_x;
    logic signed [WIDTH-1:0] unit_y;
    logic signed [WIDTH-1:0] unit_z;
    logic                    used_fallback;

    modport source (
        output valid, output unit_x, output unit_y, output unit_z, output used_fallback,
        input ready
    );
    modport sink (
        input valid, input unit_x, input unit_y, input unit_z, input used_fallback,
        output ready
    );
endinterface

FILE: sv/v3n_root_step.sv
`timescale 1ns / 1ps
// one bit of the scaled inverse root recurrence: largest t with t*t*s <= n
module v3n_root_step #(
    parameter int RW     = 64,
    parameter int PW     = 48,
    parameter int S_W    = 32,
    parameter int ROOT_W = 16,
    parameter int BIT    = 0
) (
    input  logic [RW-1:0]     r,
    input  logic [PW-1:0]     p,
    input  logic [S_W-1:0]    s,
    input  logic [ROOT_W-1:0] t,
    output logic [RW-1:0]     r_next,
    output logic [PW-1:0]     p_next,
    output logic [ROOT_W-1:0] t_next
);
    logic [RW-1:0] p_ext;
    logic [RW-1:0] s_ext;
    logic [RW-1:0] trial;
    logic [RW:0]   diff;
    logic          ge;

    // growth of t*t*s when this bit is set: 2^(b+1)*t*s + 2^(2b)*s
    assign p_ext = RW'(p);
    assign s_ext = RW'(s);
    assign trial = (p_ext << (BIT + 1)) + (s_ext << (2 * BIT));

    // residual compare and conditional subtract
    assign diff = {1'b0, r} - {1'b0, trial};
    assign ge   = ~diff[RW];

    // update residual, running product t*s and root bits
    assign r_next = ge ? diff[RW-1:0] : r;
    assign p_next = ge ? (p + (PW'(s) << BIT)) : p;
    assign t_next = t | (ROOT_W'(ge) << BIT);
endmodule

FILE: sv/vector3_normalize_with_fallback_core.sv
`timescale 1ns / 1ps
// vector normalizer: signed Q3.12 vector in, rounded signed Q1.14 unit vector or fallback out
// throughput: one transaction per cycle unless the output stalls; one stage per root bit
// stalls hold each item in place and bubbles close up, so input keeps flowing while stages are free
// reset: clears all stage valid bits, epsilon_sq to 17, fallback to (0, 0, 1.0)
module vector3_normalize_with_fallback_core #(
    parameter int COMPONENT_WIDTH      = 16,
    parameter int OUTPUT_FRACTION_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    v3n_in_if.sink                           vec_in,
    v3n_out_if.source                        unit_out,
    input  logic                             cfg_we,
    input  logic [v3n_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [v3n_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import v3n_pkg::*;

    localparam int C      = COMPONENT_WIDTH;
    localparam int F      = OUTPUT_FRACTION_BITS;
    localparam int K      = F + 2;
    localparam int SQ_W   = 2 * C - 1;
    localparam int S_W    = 2 * C;
    localparam int RW     = 2 * C + 2 * K;
    localparam int PW     = 2 * C + K;
    localparam int NS     = K + 4;
    localparam int CMP_W  = (S_W > EPS_W) ? S_W : EPS_W;
    localparam int VW     = ((K + 1 > C) ? K + 1 : C) + 1;

    localparam logic [C-1:0] FB_X_INIT = C'(FALLBACK_X_RESET);
    localparam logic [C-1:0] FB_Y_INIT = C'(FALLBACK_Y_RESET);
    localparam logic [C-1:0] FB_Z_INIT = C'(FALLBACK_Z_RESET);
    localparam logic signed [VW-1:0] MAXV = VW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] MINV = ~MAXV;
    localparam logic [K-1:0] T_MAX = K'(1) << (F + 1);

    // configuration registers
    logic [EPS_W-1:0] epsilon_sq_reg;
    logic [C-1:0]     fallback_reg [3];

    // pipeline control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   en;

    // stage payloads
    logic [C-1:0]    comp_in  [3];
    logic [C-1:0]    mag_next [3];
    logic [C-1:0]    mag_reg  [3];
    logic            sgn_next [3];
    logic            sgn_reg  [0:K+2][0:2];
    logic [2*C-1:0]  sq_full  [3];
    logic [SQ_W-1:0] sq_next  [3];
    logic [SQ_W-1:0] sq_reg   [3];
    logic [S_W-1:0]  s_next;
    logic [RW-1:0]   r0_next  [0:2];
    logic [S_W-1:0]  s_reg    [0:K-1];
    logic [RW-1:0]   r_reg    [0:K-1][0:2];
    logic [PW-1:0]   p_reg    [1:K-1][0:2];
    logic [K-1:0]    t_reg    [1:K][0:2];
    logic            flag_reg [1:K];

    // output stage
    logic [K:0]           t_inc     [3];
    logic [K-1:0]         q_mag     [3];
    logic signed [VW-1:0] q_signed  [3];
    logic signed [VW-1:0] q_val     [3];
    logic signed [VW-1:0] q_clamp   [3];
    logic [C-1:0]         unit_next [3];
    logic [C-1:0]         unit_reg  [3];
    logic                 used_fallback_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_sq_reg  <= EPS_RESET;
            fallback_reg[0] <= FB_X_INIT;
            fallback_reg[1] <= FB_Y_INIT;
            fallback_reg[2] <= FB_Z_INIT;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_EPSILON_SQ: epsilon_sq_reg  <= cfg_data[EPS_W-1:0];
                REG_FALLBACK_X: fallback_reg[0] <= cfg_data[C-1:0];
                REG_FALLBACK_Y: fallback_reg[1] <= cfg_data[C-1:0];
                REG_FALLBACK_Z: fallback_reg[2] <= cfg_data[C-1:0];
                default:        epsilon_sq_reg  <= epsilon_sq_reg;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its content moves on
    always_comb
    begin
        en[NS] = unit_out.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    // valid bits travel with the data
    always_comb
    begin
        v_next[0] = en[0] ? vec_in.valid : v_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // input stage: magnitude and sign of each component
    assign comp_in[0] = vec_in.vec_x;
    assign comp_in[1] = vec_in.vec_y;
    assign comp_in[2] = vec_in.vec_z;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sgn_next[l] = comp_in[l][C-1];
            mag_next[l] = comp_in[l][C-1] ? (~comp_in[l] + 1'b1) : comp_in[l];
        end
    end

    // squares of the magnitudes
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sq_full[l] = (2 * C)'(mag_reg[l]) * (2 * C)'(mag_reg[l]);
            sq_next[l] = sq_full[l][SQ_W-1:0];
        end
    end

    // squared length and per-lane numerator (2*|c|*2^F)^2
    always_comb
    begin
        s_next = S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);
        for (int l = 0; l < 3; l++)
        begin
            r0_next[l] = RW'(sq_reg[l]) << (2 * F + 2);
        end
    end

    // front stage registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg    <= mag_next;
            sgn_reg[0] <= sgn_next;
        end
        if (en[1])
        begin
            sq_reg <= sq_next;
        end
        if (en[2])
        begin
            s_reg[0] <= s_next;
            r_reg[0] <= r0_next;
        end
        for (int i = 1; i <= K + 2; i++)
        begin
            if (en[i])
            begin
                sgn_reg[i] <= sgn_reg[i-1];
            end
        end
    end

    // root recurrence: one stage per bit of t, most significant first
    for (genvar j = 0; j < K; j++)
    begin : g_step
        logic [PW-1:0] p_in  [3];
        logic [K-1:0]  t_in  [3];
        logic [K-1:0]  t_out [3];
        logic          flag_next;

        // short-vector test rides along with the first step
        if (j == 0)
        begin : g_first
            assign flag_next = (CMP_W'(s_reg[0]) < CMP_W'(epsilon_sq_reg))
                               || (s_reg[0] == '0);
        end
        else
        begin : g_carry
            assign flag_next = flag_reg[j];
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            if (j == 0)
            begin : g_init
                assign p_in[l] = '0;
                assign t_in[l] = '0;
            end
            else
            begin : g_chain
                assign p_in[l] = p_reg[j][l];
                assign t_in[l] = t_reg[j][l];
            end
        end

        if (j < K - 1)
        begin : g_mid
            logic [RW-1:0] r_out [3];
            logic [PW-1:0] p_out [3];

            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                v3n_root_step #(
                    .RW     (RW),
                    .PW     (PW),
                    .S_W    (S_W),
                    .ROOT_W (K),
                    .BIT    (K - 1 - j)
                ) u_step (
                    .r      (r_reg[j][l]),
                    .p      (p_in[l]),
                    .s      (s_reg[j]),
                    .t      (t_in[l]),
                    .r_next (r_out[l]),
                    .p_next (p_out[l]),
                    .t_next (t_out[l])
                );
            end

            always_ff @(posedge clk)
            begin
                if (en[3+j])
                begin
                    r_reg[j+1]    <= r_out;
                    p_reg[j+1]    <= p_out;
                    t_reg[j+1]    <= t_out;
                    s_reg[j+1]    <= s_reg[j];
                    flag_reg[j+1] <= flag_next;
                end
            end
        end
        else
        begin : g_last
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                v3n_root_step #(
                    .RW     (RW),
                    .PW     (PW),
                    .S_W    (S_W),
                    .ROOT_W (K),
                    .BIT    (K - 1 - j)
                ) u_step (
                    .r      (r_reg[j][l]),
                    .p      (p_in[l]),
                    .s      (s_reg[j]),
                    .t      (t_in[l]),
                    .r_next (),
                    .p_next (),
                    .t_next (t_out[l])
                );
            end

            always_ff @(posedge clk)
            begin
                if (en[3+j])
                begin
                    t_reg[j+1]    <= t_out;
                    flag_reg[j+1] <= flag_next;
                end
            end
        end
    end

    // round half up, apply sign, saturate, pick fallback
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            t_inc[l]    = {1'b0, t_reg[K][l]} + (K + 1)'(1);
            q_mag[l]    = t_inc[l][K:1];
            q_signed[l] = signed'(VW'(q_mag[l]));
            q_val[l]    = sgn_reg[K+2][l] ? -q_signed[l] : q_signed[l];
            if (q_val[l] > MAXV)
            begin
                q_clamp[l] = MAXV;
            end
            else if (q_val[l] < MINV)
            begin
                q_clamp[l] = MINV;
            end
            else
            begin
                q_clamp[l] = q_val[l];
            end
            unit_next[l] = flag_reg[K] ? fallback_reg[l] : q_clamp[l][C-1:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            unit_reg          <= unit_next;
            used_fallback_reg <= flag_reg[K];
        end
    end

    // channel hookup
    assign vec_in.ready           = en[0];
    assign unit_out.valid         = v_reg[NS-1];
    assign unit_out.unit_x        = unit_reg[0];
    assign unit_out.unit_y        = unit_reg[1];
    assign unit_out.unit_z        = unit_reg[2];
    assign unit_out.used_fallback = used_fallback_reg;

`ifndef NO_ASSERTIONS
    // input is refused only when every stage is full and the output is stalled
    a_ready_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !vec_in.ready |-> ((&v_reg) && !unit_out.ready))
        else $error("input refused while a pipeline stage is free");

    // the scaled root never exceeds twice the unit value
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[K+2] && !flag_reg[K]) |->
            ((t_reg[K][0] <= T_MAX) && (t_reg[K][1] <= T_MAX) && (t_reg[K][2] <= T_MAX)))
        else $error("root recurrence result out of range");

    // a normalized vector always has a nonzero component
    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_out.valid && !unit_out.used_fallback) |->
            ((unit_out.unit_x != '0) || (unit_out.unit_y != '0) || (unit_out.unit_z != '0)))
        else $error("normalized result is the zero vector");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the vector normalizer with short-vector fallback
module testbench;
    import v3n_pkg::*;

    localparam int COMP_W     = 16;
    localparam int FRAC_BITS  = 14;
    localparam int LATENCY    = FRAC_BITS + 6;
    localparam int CYCLE_CAP  = 300000;
    localparam int RAND_PHASE = 90;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct {
        comp_t unit_x;
        comp_t unit_y;
        comp_t unit_z;
        logic  used_fallback;
    } unit_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    v3n_in_if  #(.WIDTH(COMP_W)) vec_ch ();
    v3n_out_if #(.WIDTH(COMP_W)) unit_ch ();

    vector3_normalize_with_fallback_core #(
        .COMPONENT_WIDTH      (COMP_W),
        .OUTPUT_FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_in    (vec_ch),
        .unit_out  (unit_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the configuration registers
    logic [EPS_W-1:0] eps_shadow;
    comp_t            fallback_shadow [3];

    unit_result_t pending_units [$];
    int           fail_count;
    int           cycle_count;
    bit           stall_en;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("vector3_normalize_with_fallback_core verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        unit_ch.ready <= !stall_en || ($urandom_range(0, 99) >= 27);
    end

    // rounded |c| * 2^F / sqrt(sq), largest q with (2q-1)^2 * sq <= (2|c| 2^F)^2
    function automatic longint unsigned round_scaled(longint unsigned mag,
                                                     longint unsigned sq);
        longint unsigned top;
        longint unsigned num;
        longint unsigned rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned d;
        top = 64'd1 << FRAC_BITS;
        num = 2 * mag * top;
        rhs = num * num;
        lo  = 0;
        hi  = top;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            d   = 2 * mid - 1;
            if (d * d * sq <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // expected unit vector or fallback for one input vector
    function automatic unit_result_t predict_unit(comp_t x, comp_t y, comp_t z);
        unit_result_t    res;
        longint          comp [3];
        longint          q;
        longint unsigned mag;
        longint unsigned sq;
        longint          max_v;
        comp_t           outv [3];
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        max_v   = (64'sd1 <<< (COMP_W - 1)) - 1;
        sq      = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = (comp[i] < 0) ? -comp[i] : comp[i];
            sq  = sq + mag * mag;
        end
        if (sq < eps_shadow || sq == 0)
        begin
            outv = fallback_shadow;
            res.used_fallback = 1'b1;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag = (comp[i] < 0) ? -comp[i] : comp[i];
                q   = round_scaled(mag, sq);
                if (comp[i] < 0)
                    q = -q;
                if (q > max_v)
                    q = max_v;
                if (q < -max_v - 1)
                    q = -max_v - 1;
                outv[i] = comp_t'(q);
            end
            res.used_fallback = 1'b0;
        end
        res.unit_x = outv[0];
        res.unit_y = outv[1];
        res.unit_z = outv[2];
        return res;
    endfunction

    // result checker: a transaction is decided at the falling edge and taken at the next rise
    always @(negedge clk)
    begin
        unit_result_t exp_u;
        if (rst_n === 1'b1 && unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1)
        begin
            if (pending_units.size() == 0)
            begin
                $error("unexpected result transaction: unit (%0d, %0d, %0d) flag %0b",
                       unit_ch.unit_x, unit_ch.unit_y, unit_ch.unit_z, unit_ch.used_fallback);
                fail_count++;
            end
            else
            begin
                exp_u = pending_units.pop_front();
                if (unit_ch.unit_x !== exp_u.unit_x)
                begin
                    $error("unit_x expected %0d actual %0d", exp_u.unit_x, unit_ch.unit_x);
                    fail_count++;
                end
                if (unit_ch.unit_y !== exp_u.unit_y)
                begin
                    $error("unit_y expected %0d actual %0d", exp_u.unit_y, unit_ch.unit_y);
                    fail_count++;
                end
                if (unit_ch.unit_z !== exp_u.unit_z)
                begin
                    $error("unit_z expected %0d actual %0d", exp_u.unit_z, unit_ch.unit_z);
                    fail_count++;
                end
                if (unit_ch.used_fallback !== exp_u.used_fallback)
                begin
                    $error("used_fallback expected %0b actual %0b",
                           exp_u.used_fallback, unit_ch.used_fallback);
                    fail_count++;
                end
            end
        end
    end

    // send one vector; entered and left at a rising edge, valid stays high unless a gap is drawn
    task automatic send_vector(input comp_t x, input comp_t y, input comp_t z);
        if (stall_en && $urandom_range(0, 99) < 27)
        begin
            vec_ch.valid <= 1'b0;
            vec_ch.vec_x <= comp_t'($urandom);
            vec_ch.vec_y <= comp_t'($urandom);
            vec_ch.vec_z <= comp_t'($urandom);
            @(posedge clk);
            while ($urandom_range(0, 99) < 27)
                @(posedge clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.vec_x <= x;
        vec_ch.vec_y <= y;
        vec_ch.vec_z <= z;
        do
            @(negedge clk);
        while (vec_ch.ready !== 1'b1);
        pending_units.push_back(predict_unit(x, y, z));
        @(posedge clk);
    endtask

    // stop the input stream and wait until every result has come back
    task automatic drain_results();
        vec_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // write all four registers on consecutive cycles; upper data bits of fallbacks are junk
    task automatic write_regs(input logic [EPS_W-1:0] eps, input comp_t fx,
                              input comp_t fy, input comp_t fz);
        cfg_we    <= 1'b1;
        cfg_index <= REG_EPSILON_SQ;
        cfg_data  <= eps;
        @(posedge clk);
        cfg_index <= REG_FALLBACK_X;
        cfg_data  <= {16'($urandom), fx};
        @(posedge clk);
        cfg_index <= REG_FALLBACK_Y;
        cfg_data  <= {16'($urandom), fy};
        @(posedge clk);
        cfg_index <= REG_FALLBACK_Z;
        cfg_data  <= {16'($urandom), fz};
        @(posedge clk);
        cfg_we <= 1'b0;
        eps_shadow         = eps;
        fallback_shadow[0] = fx;
        fallback_shadow[1] = fy;
        fallback_shadow[2] = fz;
        @(posedge clk);
    endtask

    // reset register values: zero and tiny vectors fall back, edges of the range normalize
    task automatic test_reset_defaults();
        send_vector(0, 0, 0);
        send_vector(1, 2, 2);
        send_vector(1, 0, 0);
        send_vector(4, 1, 0);
        send_vector(32767, 0, 0);
        send_vector(-32768, 0, 0);
        send_vector(0, -32768, 0);
        send_vector(0, 0, 32767);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, -32768, -32768);
        send_vector(-32768, 32767, -1);
        drain_results();
    endtask

    // zero threshold: only the zero vector takes the fallback
    task automatic test_zero_epsilon();
        write_regs(32'd0, -32768, 32767, -1);
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        send_vector(0, 0, -1);
        send_vector(1, 1, 1);
        send_vector(-1, -1, 0);
        drain_results();
    endtask

    // full-scale threshold: every vector is short
    task automatic test_max_epsilon();
        write_regs(32'hFFFF_FFFF, 32767, -32768, 0);
        send_vector(32767, 32767, 32767);
        send_vector(-32768, -32768, -32768);
        send_vector(12345, -23456, 345);
        drain_results();
    endtask

    // squared length equal to the threshold normalizes, one just below falls back
    task automatic test_epsilon_boundary();
        write_regs(32'd25, 16384, -16384, 100);
        send_vector(3, 4, 0);
        send_vector(2, 2, 4);
        drain_results();
        write_regs(32'h4000_0000, -5, 7, -16384);
        send_vector(-32768, 0, 0);
        send_vector(32767, 0, 0);
        drain_results();
    endtask

    // random threshold drawn from several useful regions
    function automatic logic [EPS_W-1:0] pick_epsilon();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return EPS_RESET;
            2:       return $urandom_range(0, 4096);
            3:       return $urandom;
            4:       return $urandom_range(32'h0010_0000, 32'h4000_0000);
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // random vector with a mix of magnitudes and shapes
    task automatic send_random_vector();
        comp_t v [3];
        int    sh;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                foreach (v[i]) v[i] = comp_t'($urandom);
            end
            3, 4:
            begin
                foreach (v[i]) v[i] = comp_t'($urandom_range(0, 128)) - 16'sd64;
            end
            5:
            begin
                foreach (v[i]) v[i] = '0;
                v[$urandom_range(0, 2)] = comp_t'($urandom);
            end
            6, 7:
            begin
                sh = $urandom_range(0, 15);
                foreach (v[i]) v[i] = comp_t'($urandom) >>> sh;
            end
            8:
            begin
                foreach (v[i]) v[i] = comp_t'($urandom_range(0, 6)) - 16'sd3;
                v[$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            end
            default:
            begin
                foreach (v[i]) v[i] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            end
        endcase
        send_vector(v[0], v[1], v[2]);
    endtask

    // random phases under changing configuration, one phase without idling
    task automatic test_random_stream();
        for (int phase = 0; phase < 5; phase++)
        begin
            write_regs(pick_epsilon(), comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
            stall_en = (phase != 3);
            for (int n = 0; n < RAND_PHASE; n++)
            begin
                // hold the sender off until the block has emptied
                if (phase == 1 && n == RAND_PHASE / 2)
                    drain_results();
                send_random_vector();
            end
            drain_results();
            stall_en = 1'b1;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_EPSILON_SQ;
        cfg_data        = '0;
        vec_ch.valid    = 1'b0;
        vec_ch.vec_x    = '0;
        vec_ch.vec_y    = '0;
        vec_ch.vec_z    = '0;
        unit_ch.ready   = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        stall_en        = 1'b1;
        eps_shadow         = EPS_RESET;
        fallback_shadow[0] = comp_t'(FALLBACK_X_RESET);
        fallback_shadow[1] = comp_t'(FALLBACK_Y_RESET);
        fallback_shadow[2] = comp_t'(FALLBACK_Z_RESET);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_epsilon();
        test_max_epsilon();
        test_epsilon_boundary();
        test_random_stream();

        drain_results();
        if (fail_count == 0)
            $display("vector3_normalize_with_fallback_core verification clean");
        else
            $display("vector3_normalize_with_fallback_core verification failed");
        $finish;
    end

endmodule

FILE: vector3_normalize_with_fallback_core.f
sv/v3n_pkg.sv
sv/v3n_in_if.sv
sv/v3n_out_if.sv
sv/v3n_root_step.sv
sv/vector3_normalize_with_fallback_core.sv
tb/testbench.sv
